// File: hw/rtl/rbst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Face codes and the status group shared by the lanes and the merge stage.
// ----------------------------------------------------------------------------
package rbst_pkg;

  typedef logic [1:0] face_t;

  // axis is code / 2, normal is +1 for even codes and -1 for odd codes
  localparam face_t FACE_POS_X = 2'd0;
  localparam face_t FACE_NEG_X = 2'd1;
  localparam face_t FACE_POS_Y = 2'd2;
  localparam face_t FACE_NEG_Y = 2'd3;

  typedef struct packed {
    logic  par;   // direction treated as parallel to the slab
    logic  miss;  // parallel and start outside the slab
    face_t f_lo;  // face of the near slab plane
    face_t f_hi;  // face of the far slab plane
  } lane_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/rbst_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// (n << F) / d truncated, signed by neg and saturated to W bits.
// ----------------------------------------------------------------------------
module rbst_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic [W:0]          n,
  input  wire logic [W-1:0]        d,
  input  wire logic                neg,
  output logic signed [W-1:0]      t
);

  localparam int NS = W - 1;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [W+F:0] nf;
  logic [F+1:0] nhi;
  logic         ovf0;

  logic [W-1:0] rem_r [0:NS];
  logic [W-2:0] q_r   [0:NS];
  logic [W-2:0] low_r [0:NS];
  logic [W-1:0] den_r [0:NS];
  logic         ovf_r [0:NS];
  logic         neg_r [0:NS];

  logic [W-1:0] trial [1:NS];
  logic         ge    [1:NS];
  logic [W-1:0] qs;

  assign nf   = {n, {F{1'b0}}};
  assign nhi  = nf[W+F:W-1];
  // quotient reaches the cap when the leading part already holds the divisor
  assign ovf0 = {{W{1'b0}}, nhi} >= {{(F+2){1'b0}}, d};

  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      trial[k] = {rem_r[k-1][W-2:0], low_r[k-1][W-2]};
      ge[k]    = trial[k] >= den_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= ovf0 ? '0 : W'(nhi);
      q_r[0]   <= '0;
      low_r[0] <= nf[W-2:0];
      den_r[0] <= d;
      ovf_r[0] <= ovf0;
      neg_r[0] <= neg;
      for (int k = 1; k <= NS; k++) begin
        rem_r[k] <= ge[k] ? (trial[k] - den_r[k-1]) : trial[k];
        q_r[k]   <= {q_r[k-1][W-3:0], ge[k]};
        low_r[k] <= {low_r[k-1][W-3:0], 1'b0};
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign qs = {1'b0, q_r[NS]};

  always_comb begin
    if (neg_r[NS]) begin
      t = ovf_r[NS] ? SMIN : -$signed(qs);
    end else begin
      t = ovf_r[NS] ? SMAX : $signed(qs);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rbst_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_lane
// Slab test for one axis: parallel check, two slab-time dividers and the
// swap of near and far planes for a negative direction.
// ----------------------------------------------------------------------------
module rbst_lane import rbst_pkg::*; #(
  parameter int W    = 32,
  parameter int F    = 16,
  parameter int AXIS = 0
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic [W-2:0]        eps,
  input  wire logic signed [W-1:0] s,
  input  wire logic signed [W-1:0] d,
  input  wire logic signed [W-1:0] bmin,
  input  wire logic signed [W-1:0] bmax,
  output logic signed [W-1:0]      t_lo,
  output logic signed [W-1:0]      t_hi,
  output lane_stat_t               stat
);

  localparam face_t F_POS = (AXIS == 0) ? FACE_POS_X : FACE_POS_Y;
  localparam face_t F_NEG = (AXIS == 0) ? FACE_NEG_X : FACE_NEG_Y;

  logic [W-1:0]        dmag;
  logic                par;
  logic                miss;
  logic signed [W:0]   num0;
  logic signed [W:0]   num1;
  logic [W:0]          mag0;
  logic [W:0]          mag1;

  logic [W:0]          n0_r;
  logic [W:0]          n1_r;
  logic                neg0_r;
  logic                neg1_r;
  logic [W-1:0]        dmag_r;
  // par, miss, direction sign carried alongside the dividers
  logic [2:0]          fl_r [0:W];

  logic signed [W-1:0] t0;
  logic signed [W-1:0] t1;
  logic                dneg;

  assign dmag = d[W-1] ? (~d + 1'b1) : d;
  assign par  = (d == '0) || (dmag < {1'b0, eps});
  assign miss = (s < bmin) || (bmax < s);
  assign num0 = {bmin[W-1], bmin} - {s[W-1], s};
  assign num1 = {bmax[W-1], bmax} - {s[W-1], s};
  assign mag0 = num0[W] ? (~num0 + 1'b1) : num0;
  assign mag1 = num1[W] ? (~num1 + 1'b1) : num1;

  always_ff @(posedge clk) begin
    if (adv) begin
      n0_r    <= mag0;
      n1_r    <= mag1;
      neg0_r  <= num0[W] ^ d[W-1];
      neg1_r  <= num1[W] ^ d[W-1];
      dmag_r  <= dmag;
      fl_r[0] <= {par, miss, d[W-1]};
      for (int k = 1; k <= W; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  rbst_div #(.W(W), .F(F)) u_div_min (
    .clk (clk),
    .adv (adv),
    .n   (n0_r),
    .d   (dmag_r),
    .neg (neg0_r),
    .t   (t0)
  );

  rbst_div #(.W(W), .F(F)) u_div_max (
    .clk (clk),
    .adv (adv),
    .n   (n1_r),
    .d   (dmag_r),
    .neg (neg1_r),
    .t   (t1)
  );

  assign dneg      = fl_r[W][0];
  assign t_lo      = dneg ? t1 : t0;
  assign t_hi      = dneg ? t0 : t1;
  assign stat.par  = fl_r[W][2];
  assign stat.miss = fl_r[W][1];
  assign stat.f_lo = dneg ? F_NEG : F_POS;
  assign stat.f_hi = dneg ? F_POS : F_NEG;

endmodule
`default_nettype wire

// File: hw/rtl/rbst_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_merge
// Narrows the interval from zero to the largest time with the x lane, then
// with the y lane, one register stage per axis.
// ----------------------------------------------------------------------------
module rbst_merge import rbst_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic signed [W-1:0] tlo_x,
  input  wire logic signed [W-1:0] thi_x,
  input  wire lane_stat_t          st_x,
  input  wire logic signed [W-1:0] tlo_y,
  input  wire logic signed [W-1:0] thi_y,
  input  wire lane_stat_t          st_y,
  output logic signed [W-1:0]      te,
  output logic signed [W-1:0]      tx,
  output face_t                    fe,
  output face_t                    fx,
  output logic                     hit
);

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  logic                upd_e1;
  logic                upd_x1;
  logic signed [W-1:0] te1;
  logic signed [W-1:0] tx1;

  logic signed [W-1:0] te1_r;
  logic signed [W-1:0] tx1_r;
  face_t               fe1_r;
  face_t               fx1_r;
  logic                hit1_r;
  logic signed [W-1:0] tlo_y_r;
  logic signed [W-1:0] thi_y_r;
  lane_stat_t          st_y_r;

  logic                upd_e2;
  logic                upd_x2;
  logic signed [W-1:0] te2;
  logic signed [W-1:0] tx2;

  logic signed [W-1:0] te_r;
  logic signed [W-1:0] tx_r;
  face_t               fe_r;
  face_t               fx_r;
  logic                hit_r;

  assign upd_e1 = !st_x.par && (tlo_x > $signed({W{1'b0}}));
  assign upd_x1 = !st_x.par && (thi_x < SMAX);
  assign te1    = upd_e1 ? tlo_x : '0;
  assign tx1    = upd_x1 ? thi_x : SMAX;

  assign upd_e2 = !st_y_r.par && (tlo_y_r > te1_r);
  assign upd_x2 = !st_y_r.par && (thi_y_r < tx1_r);
  assign te2    = upd_e2 ? tlo_y_r : te1_r;
  assign tx2    = upd_x2 ? thi_y_r : tx1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      te1_r   <= te1;
      tx1_r   <= tx1;
      fe1_r   <= upd_e1 ? st_x.f_lo : FACE_POS_X;
      fx1_r   <= upd_x1 ? st_x.f_hi : FACE_POS_X;
      hit1_r  <= st_x.par ? !st_x.miss : !(tx1 < te1);
      tlo_y_r <= tlo_y;
      thi_y_r <= thi_y;
      st_y_r  <= st_y;

      te_r  <= te2;
      tx_r  <= tx2;
      fe_r  <= upd_e2 ? st_y_r.f_lo : fe1_r;
      fx_r  <= upd_x2 ? st_y_r.f_hi : fx1_r;
      hit_r <= hit1_r && (st_y_r.par ? !st_y_r.miss : !(tx2 < te2));
    end
  end

  assign te  = te_r;
  assign tx  = tx_r;
  assign fe  = fe_r;
  assign fx  = fx_r;
  assign hit = hit_r;

endmodule
`default_nettype wire

// File: hw/rtl/rbst_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_point
// Point on the ray, s + d * t, product truncated to F fraction bits and the
// sum saturated. Partial products, sum, then shift and clamp: three stages.
// ----------------------------------------------------------------------------
module rbst_point #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic signed [W-1:0] s,
  input  wire logic signed [W-1:0] d,
  input  wire logic [W-2:0]        t,
  output logic signed [W-1:0]      p
);

  localparam int HA = W / 2;
  localparam int HB = (W - 1) / 2;
  localparam int PW = 2 * W - 1;
  localparam int SW = PW - F;
  localparam logic [SW-1:0] PCAP = SW'(1) << W;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]           a;
  logic [HA+HB-1:0]       pp00_r;
  logic [HA+W-1-HB-1:0]   pp01_r;
  logic [W-HA+HB-1:0]     pp10_r;
  logic [2*W-1-HA-HB-1:0] pp11_r;
  logic signed [W-1:0]    s1_r;
  logic                   neg1_r;

  logic [PW-1:0]          prod_r;
  logic signed [W-1:0]    s2_r;
  logic                   neg2_r;

  logic [SW-1:0]          psh;
  logic [W:0]             pmag;
  logic signed [W+1:0]    ps;
  logic signed [W+1:0]    sum;
  logic                   ovp;
  logic                   ovn;
  logic signed [W-1:0]    p_r;

  assign a = d[W-1] ? (~d + 1'b1) : d;

  assign psh  = prod_r[PW-1:F];
  assign pmag = (psh > PCAP) ? {1'b1, {W{1'b0}}} : psh[W:0];
  assign ps   = neg2_r ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
  assign sum  = $signed({{2{s2_r[W-1]}}, s2_r}) + ps;
  assign ovp  = !sum[W+1] && (sum[W:W-1] != 2'b00);
  assign ovn  = sum[W+1] && (sum[W:W-1] != 2'b11);

  always_ff @(posedge clk) begin
    if (adv) begin
      pp00_r <= a[HA-1:0] * t[HB-1:0];
      pp01_r <= a[HA-1:0] * t[W-2:HB];
      pp10_r <= a[W-1:HA] * t[HB-1:0];
      pp11_r <= a[W-1:HA] * t[W-2:HB];
      s1_r   <= s;
      neg1_r <= d[W-1];

      prod_r <= PW'(pp00_r) + (PW'(pp01_r) << HB) + (PW'(pp10_r) << HA)
                + (PW'(pp11_r) << (HA + HB));
      s2_r   <= s1_r;
      neg2_r <= neg1_r;

      p_r <= ovp ? SMAX : (ovn ? SMIN : sum[W-1:0]);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// File: hw/rtl/ray_box_slab_test_2d_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test_2d_core
// 2D ray against axis-aligned box by the slab method, one lane per axis.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                         | tuser
//  in_     | in  | ray start, direction, box corners    | -
//  out_    | out | times, faces, entry and exit points  | hit
//  cfg_    | in  | parallel threshold                   | -
//
// One item per cycle while the skid register is empty; the per-axis dividers
// resolve one quotient bit per stage. The whole pipeline advances together;
// an output register plus a skid register let one more result leave while
// the output is stalled.
// rst_n clears the valid bits, the skid and the threshold (back to 1).
// ----------------------------------------------------------------------------
module ray_box_slab_test_2d_core import rbst_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // start_x, start_y, dir_x, dir_y, box_min_x, box_min_y, box_max_x, box_max_y
  input  wire logic [8*COORD_WIDTH-1:0]   in_tdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // t_enter, t_exit, enter_face, exit_face, enter_x, enter_y, exit_x, exit_y
  output logic [((6*COORD_WIDTH+2+7)/8)*8-1:0] out_tdata,
  // hit
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [COORD_WIDTH-2:0]     cfg_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int OW  = ((6 * W + 2 + 7) / 8) * 8;
  localparam int DL  = W + 3;  // register index of the merge result
  localparam int LAT = W + 7;

  logic                en;
  logic [W-2:0]        eps_r;

  logic                vld_r [0:LAT-1];
  logic signed [W-1:0] st_r  [0:DL][0:1];
  logic signed [W-1:0] dr_r  [0:DL][0:1];
  logic signed [W-1:0] bmin_r [0:1];
  logic signed [W-1:0] bmax_r [0:1];

  logic signed [W-1:0] tlo [0:1];
  logic signed [W-1:0] thi [0:1];
  lane_stat_t          lst [0:1];

  logic signed [W-1:0] m_te;
  logic signed [W-1:0] m_tx;
  face_t               m_fe;
  face_t               m_fx;
  logic                m_hit;

  logic signed [W-1:0] pt_en [0:1];
  logic signed [W-1:0] pt_ex [0:1];

  logic signed [W-1:0] te_d_r  [0:2];
  logic signed [W-1:0] tx_d_r  [0:2];
  face_t               fe_d_r  [0:2];
  face_t               fx_d_r  [0:2];
  logic                hit_d_r [0:2];

  logic [OW-1:0]       pipe_data;
  logic                pipe_vld;
  logic                pipe_hit;
  logic                take;

  logic [OW-1:0]       out_data_r;
  logic                out_hit_r;
  logic                out_valid_r;
  logic [OW-1:0]       skid_data_r;
  logic                skid_hit_r;
  logic                skid_full_r;

  assign en        = !skid_full_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= (W-1)'(1);
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0][0] <= in_tdata[W-1:0];
      st_r[0][1] <= in_tdata[2*W-1:W];
      dr_r[0][0] <= in_tdata[3*W-1:2*W];
      dr_r[0][1] <= in_tdata[4*W-1:3*W];
      bmin_r[0]  <= in_tdata[5*W-1:4*W];
      bmin_r[1]  <= in_tdata[6*W-1:5*W];
      bmax_r[0]  <= in_tdata[7*W-1:6*W];
      bmax_r[1]  <= in_tdata[8*W-1:7*W];
      for (int k = 1; k <= DL; k++) begin
        st_r[k] <= st_r[k-1];
        dr_r[k] <= dr_r[k-1];
      end
      te_d_r[0]  <= m_te;
      tx_d_r[0]  <= m_tx;
      fe_d_r[0]  <= m_fe;
      fx_d_r[0]  <= m_fx;
      hit_d_r[0] <= m_hit;
      for (int k = 1; k < 3; k++) begin
        te_d_r[k]  <= te_d_r[k-1];
        tx_d_r[k]  <= tx_d_r[k-1];
        fe_d_r[k]  <= fe_d_r[k-1];
        fx_d_r[k]  <= fx_d_r[k-1];
        hit_d_r[k] <= hit_d_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    rbst_lane #(.W(W), .F(F), .AXIS(g)) u_lane (
      .clk  (clk),
      .adv  (en),
      .eps  (eps_r),
      .s    (st_r[0][g]),
      .d    (dr_r[0][g]),
      .bmin (bmin_r[g]),
      .bmax (bmax_r[g]),
      .t_lo (tlo[g]),
      .t_hi (thi[g]),
      .stat (lst[g])
    );

    rbst_point #(.W(W), .F(F)) u_pt_enter (
      .clk (clk),
      .adv (en),
      .s   (st_r[DL][g]),
      .d   (dr_r[DL][g]),
      .t   (m_te[W-2:0]),
      .p   (pt_en[g])
    );

    rbst_point #(.W(W), .F(F)) u_pt_exit (
      .clk (clk),
      .adv (en),
      .s   (st_r[DL][g]),
      .d   (dr_r[DL][g]),
      .t   (m_tx[W-2:0]),
      .p   (pt_ex[g])
    );
  end

  rbst_merge #(.W(W)) u_merge (
    .clk   (clk),
    .adv   (en),
    .tlo_x (tlo[0]),
    .thi_x (thi[0]),
    .st_x  (lst[0]),
    .tlo_y (tlo[1]),
    .thi_y (thi[1]),
    .st_y  (lst[1]),
    .te    (m_te),
    .tx    (m_tx),
    .fe    (m_fe),
    .fx    (m_fx),
    .hit   (m_hit)
  );

  // a miss reports zeros in every field
  assign pipe_hit  = hit_d_r[2];
  assign pipe_vld  = vld_r[LAT-1];
  assign pipe_data = pipe_hit ?
    OW'({pt_ex[1], pt_ex[0], pt_en[1], pt_en[0], fx_d_r[2], fe_d_r[2],
         tx_d_r[2][W-2:0], te_d_r[2][W-2:0]}) : '0;

  assign take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= pipe_vld;
    end else if (pipe_vld) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
        out_hit_r  <= skid_hit_r;
      end
    end else if (!out_valid_r || take) begin
      out_data_r <= pipe_data;
      out_hit_r  <= pipe_hit;
    end else begin
      skid_data_r <= pipe_data;
      skid_hit_r  <= pipe_hit;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;
  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled without an output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_data_r == '0))
    else $error("miss transaction carries non-zero fields");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_data_r[2*W-3:W-1] >= out_data_r[W-2:0]))
    else $error("exit time before entry time on a hit");
`endif

endmodule
`default_nettype wire
